// File: hw/rtl/rgbconv_pkg.sv
// Shared types, register codes and constants for the RGB 3x3 convolution core.
`default_nettype none

package rgbconv_pkg;

  parameter int MAX_WIDTH_DEF  = 2048;
  parameter int COEF_FRAC_DEF  = 12;

  parameter int FW_W    = 12;        // frame_width register
  parameter int FH_W    = 16;        // frame_height register
  parameter int ROW_W   = FH_W + 1;  // row position runs one past the height while draining
  parameter int COEF_W  = 16;
  parameter int COEFS_W = 3 * COEF_W;
  parameter int CH_W    = 8;
  parameter int PIX_W   = 3 * CH_W;
  parameter int NTAP    = 9;
  parameter int APB_AW  = 6;
  parameter int APB_DW  = 64;

  parameter logic [FW_W-1:0]    FRAME_WIDTH_RST  = 12'd640;
  parameter logic [FH_W-1:0]    FRAME_HEIGHT_RST = 16'd480;
  parameter logic [COEFS_W-1:0] COEF_PREV_RST    = 48'h0000_0999_0000;
  parameter logic [COEFS_W-1:0] COEF_CUR_RST     = 48'h0000_0800_0000;
  parameter logic [COEFS_W-1:0] COEF_NEXT_RST    = 48'h0000_F000_0000;

  typedef enum logic [2:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_COEF_PREV,
    REG_COEF_CUR,
    REG_COEF_NEXT
  } reg_idx_e;

  typedef enum logic {
    REQ_PIXEL,
    REQ_DRAIN
  } req_type_e;

  // Control carried by a request from acceptance into the line-store stage.
  typedef struct packed {
    logic            res;    // request yields a result
    logic            eof;    // result closes the frame
    logic            shift;  // advance window and write line store
    logic [NTAP-1:0] mask;   // taps inside the image
  } s1_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/rgbconv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rgbconv_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/rgb_3x3_convolution_wrap_core.sv
// Top level: RGB 3x3 convolution over a raster pixel stream.
//
//   port group  dir  data                                   accepted when
//   s_axis_*    in   tdata red/green/blue, tuser req_type    tvalid & tready
//   m_axis_*    out  tdata red/green/blue, tlast end_of_frame tvalid & tready
//   apb         in   frame size and three coefficient rows  psel & penable & pwrite
//
// One request per clock while s_axis_tready is high. A result leaves once the request that
// causes it has passed the line-store read and the nine-tap accumulation chain (one tap a stage).
// The result belongs to the pixel one row plus one pixel before that request.
// Reset clears the window and position; line store contents are not cleared.
// m_axis_tready low holds the output; stages fill and s_axis_tready drops when full.
`default_nettype none

module rgb_3x3_convolution_wrap_core
  import rgbconv_pkg::*;
#(
  parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PIX_W-1:0]  s_axis_tdata,   // pix_red, pix_green, pix_blue
  input  logic              s_axis_tuser,   // req_type
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PIX_W-1:0]  m_axis_tdata,   // out_red, out_green, out_blue
  output logic              m_axis_tlast,   // end_of_frame
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > FW_W) ? WW : FW_W;
  localparam int PW   = COEF_W + CH_W + 1;
  localparam int TW   = (((CH_W + 1 + COEF_FRAC_BITS) > PW) ?
                         (CH_W + 1 + COEF_FRAC_BITS) : PW) + 1;
  localparam int NST  = NTAP;
  localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);
  localparam logic signed [TW-1:0] BIAS = TW'((1 << COEF_FRAC_BITS) - 1);

  function automatic logic signed [PW-1:0] tap_mul(logic signed [COEF_W-1:0] cf,
                                                   logic [CH_W-1:0] p, logic en);
    logic signed [PW-1:0] a_e;
    logic signed [PW-1:0] b_e;
    a_e = PW'(cf);
    b_e = PW'($signed({1'b0, p}));
    return en ? PW'(a_e * b_e) : '0;
  endfunction

  // acc*2^F + prod, truncate toward zero, remainder by 256 keeping the sign
  function automatic logic signed [CH_W:0] acc_step(logic signed [CH_W:0] acc,
                                                    logic signed [PW-1:0] prod);
    logic signed [TW-1:0] t;
    logic signed [TW-1:0] q;
    logic [CH_W-1:0]      m;
    t = (TW'(acc) <<< COEF_FRAC_BITS) + TW'(prod);
    if (t[TW-1]) begin
      q = (t + BIAS) >>> COEF_FRAC_BITS;
    end else begin
      q = t >>> COEF_FRAC_BITS;
    end
    m = q[CH_W-1:0];
    return {q[TW-1] && (m != '0), m};
  endfunction

  // Configuration registers
  logic [FW_W-1:0]    frame_width_q, frame_width_d;
  logic [FH_W-1:0]    frame_height_q, frame_height_d;
  logic [COEFS_W-1:0] coef_prev_q, coef_prev_d;
  logic [COEFS_W-1:0] coef_cur_q, coef_cur_d;
  logic [COEFS_W-1:0] coef_next_q, coef_next_d;
  logic               cfg_wr;
  logic               dims_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[APB_AW-1:3]);

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    coef_prev_d    = coef_prev_q;
    coef_cur_d     = coef_cur_q;
    coef_next_d    = coef_next_q;
    dims_wr        = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH: begin
          frame_width_d = pwdata[FW_W-1:0];
          dims_wr       = 1'b1;
        end
        REG_HEIGHT: begin
          frame_height_d = pwdata[FH_W-1:0];
          dims_wr        = 1'b1;
        end
        REG_COEF_PREV: coef_prev_d = pwdata[COEFS_W-1:0];
        REG_COEF_CUR:  coef_cur_d  = pwdata[COEFS_W-1:0];
        REG_COEF_NEXT: coef_next_d = pwdata[COEFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:     prdata = APB_DW'(frame_width_q);
      REG_HEIGHT:    prdata = APB_DW'(frame_height_q);
      REG_COEF_PREV: prdata = APB_DW'(coef_prev_q);
      REG_COEF_CUR:  prdata = APB_DW'(coef_cur_q);
      REG_COEF_NEXT: prdata = APB_DW'(coef_next_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      coef_prev_q    <= COEF_PREV_RST;
      coef_cur_q     <= COEF_CUR_RST;
      coef_next_q    <= COEF_NEXT_RST;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      coef_prev_q    <= coef_prev_d;
      coef_cur_q     <= coef_cur_d;
      coef_next_q    <= coef_next_d;
    end
  end

  // Effective frame size
  logic [CMPW-1:0]  fw_ext;
  logic [WW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;

  always_comb begin
    fw_ext = CMPW'(frame_width_q);
    if (fw_ext == '0) begin
      eff_w = WW'(1);
    end else if (fw_ext > MAXW_C) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_ext);
    end
    eff_h = (frame_height_q == '0) ? ROW_W'(1) : ROW_W'(frame_height_q);
  end

  logic signed [COEF_W-1:0] coef_tap [NTAP];

  always_comb begin
    for (int kc = 0; kc < 3; kc++) begin
      coef_tap[kc]     = $signed(coef_prev_q[COEF_W*kc +: COEF_W]);
      coef_tap[3 + kc] = $signed(coef_cur_q[COEF_W*kc +: COEF_W]);
      coef_tap[6 + kc] = $signed(coef_next_q[COEF_W*kc +: COEF_W]);
    end
  end

  // Pipeline enables, collapsing bubbles
  logic           out_v_q;
  logic [NST-1:0] st_v_q;
  logic [NST-1:0] en_st;
  logic           out_en;
  logic           s1_v_q;
  s1_ctl_t        s1_ctl_q, s1_ctl_d;
  logic           s1_en;
  logic           s1_leave;

  always_comb begin
    out_en        = !out_v_q || m_axis_tready;
    en_st[NST-1]  = !st_v_q[NST-1] || out_en;
    for (int k = NST - 2; k >= 0; k--) begin
      en_st[k] = !st_v_q[k] || en_st[k+1];
    end
    s1_en    = !s1_v_q || !s1_ctl_q.res || en_st[0];
    s1_leave = s1_v_q && s1_en;
  end

  assign s_axis_tready = s1_en;

  // Position and acceptance decisions
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             acc_in;
  logic             drain;
  logic             rejected;
  logic             take;
  logic [CW-1:0]    c_eff;
  logic             last_col;
  logic             case_a;
  logic             case_b;
  logic             is_eof;
  logic [2:0]       row_ok;
  logic [2:0]       col_ok;

  always_comb begin
    acc_in   = s_axis_tvalid && s_axis_tready;
    drain    = req_type_e'(s_axis_tuser) == REQ_DRAIN;
    rejected = drain ? (row_q < eff_h) : (row_q >= eff_h);
    take     = acc_in && !rejected;
    c_eff    = (WW'(col_q) >= eff_w) ? '0 : col_q;
    last_col = (WW'(c_eff) + WW'(1)) == eff_w;
    case_a   = (c_eff == '0) && (row_q >= ROW_W'(2));
    case_b   = (c_eff != '0) && (row_q >= ROW_W'(1));
    is_eof   = case_a && (row_q == eff_h + ROW_W'(1));

    if (case_a) begin
      // Last column of the row two back, window not yet advanced
      row_ok = {row_q <= eff_h, 1'b1, row_q >= ROW_W'(3)};
      col_ok = {1'b0, 1'b1, eff_w >= WW'(2)};
    end else begin
      row_ok = {row_q < eff_h, 1'b1, row_q >= ROW_W'(2)};
      col_ok = {1'b1, 1'b1, c_eff >= CW'(2)};
    end

    s1_ctl_d.res   = case_a || case_b;
    s1_ctl_d.eof   = is_eof;
    s1_ctl_d.shift = !is_eof;
    for (int kr = 0; kr < 3; kr++) begin
      for (int kc = 0; kc < 3; kc++) begin
        s1_ctl_d.mask[kr*3 + kc] = row_ok[kr] && col_ok[kc];
      end
    end

    col_d = col_q;
    row_d = row_q;
    if (dims_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (take) begin
      if (is_eof) begin
        col_d = '0;
        row_d = '0;
      end else if (last_col) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = c_eff + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line store: older row in the upper half, newer row in the lower half
  logic [PIX_W-1:0]   s1_px_q;
  logic [CW-1:0]      s1_addr_q;
  logic [2*PIX_W-1:0] ram_rdata;
  logic [2*PIX_W-1:0] ls_rd;
  logic [2*PIX_W-1:0] fwd_data_q;
  logic               fwd_q, fwd_d;
  logic [CW-1:0]      ram_raddr;
  logic               ram_we;
  logic [PIX_W-1:0]   ls_old;
  logic [PIX_W-1:0]   ls_new;

  assign ls_rd     = fwd_q ? fwd_data_q : ram_rdata;
  assign ls_old    = ls_rd[2*PIX_W-1:PIX_W];
  assign ls_new    = ls_rd[PIX_W-1:0];
  assign ram_raddr = s1_en ? c_eff : s1_addr_q;
  assign ram_we    = s1_leave && s1_ctl_q.shift;
  // Bypass the store when the request behind reads the entry being written
  assign fwd_d     = ram_we && take && (c_eff == s1_addr_q);

  rgbconv_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i ({ls_new, s1_px_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_ctl_q <= '0;
      fwd_q    <= 1'b0;
    end else begin
      fwd_q <= fwd_d;
      if (s1_en) begin
        s1_v_q   <= take;
        s1_ctl_q <= s1_ctl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_px_q   <= drain ? '0 : {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
      s1_addr_q <= c_eff;
    end
    if (ram_we) begin
      fwd_data_q <= {ls_new, s1_px_q};
    end
  end

  // Window of three rows by three columns
  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] tap_s1 [NTAP];

  always_comb begin
    for (int kr = 0; kr < 3; kr++) begin
      tap_s1[kr*3]     = win_q[kr][1];
      tap_s1[kr*3 + 1] = win_q[kr][2];
    end
    tap_s1[2] = ls_old;
    tap_s1[5] = ls_new;
    tap_s1[8] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int kr = 0; kr < 3; kr++) begin
        for (int kc = 0; kc < 3; kc++) begin
          win_q[kr][kc] <= '0;
        end
      end
    end else if (dims_wr || (s1_leave && s1_ctl_q.eof)) begin
      for (int kr = 0; kr < 3; kr++) begin
        for (int kc = 0; kc < 3; kc++) begin
          win_q[kr][kc] <= '0;
        end
      end
    end else if (ram_we) begin
      for (int kr = 0; kr < 3; kr++) begin
        win_q[kr][0] <= win_q[kr][1];
        win_q[kr][1] <= win_q[kr][2];
        win_q[kr][2] <= tap_s1[kr*3 + 2];
      end
    end
  end

  // Accumulation stages: stage k forms the product of tap k, the next adds it in
  logic [PIX_W-1:0]         st_tap_q  [NST][NTAP];
  logic [PIX_W-1:0]         st_tap_d  [NST][NTAP];
  logic [NTAP-1:0]          st_mask_q [NST];
  logic [NTAP-1:0]          st_mask_d [NST];
  logic [NST-1:0]           st_eof_q, st_eof_d;
  logic signed [CH_W:0]     st_acc_q  [NST][3];
  logic signed [CH_W:0]     st_acc_d  [NST][3];
  logic signed [PW-1:0]     st_prod_q [NST][3];
  logic signed [PW-1:0]     st_prod_d [NST][3];

  always_comb begin
    st_tap_d[0]  = tap_s1;
    st_mask_d[0] = s1_ctl_q.mask;
    st_eof_d[0]  = s1_ctl_q.eof;
    for (int ch = 0; ch < 3; ch++) begin
      st_acc_d[0][ch]  = '0;
      st_prod_d[0][ch] = tap_mul(coef_tap[0], tap_s1[0][PIX_W-1-CH_W*ch -: CH_W],
                                 s1_ctl_q.mask[0]);
    end
    for (int k = 1; k < NST; k++) begin
      st_tap_d[k]  = st_tap_q[k-1];
      st_mask_d[k] = st_mask_q[k-1];
      st_eof_d[k]  = st_eof_q[k-1];
      for (int ch = 0; ch < 3; ch++) begin
        st_acc_d[k][ch]  = acc_step(st_acc_q[k-1][ch], st_prod_q[k-1][ch]);
        st_prod_d[k][ch] = tap_mul(coef_tap[k],
                                   st_tap_q[k-1][k][PIX_W-1-CH_W*ch -: CH_W],
                                   st_mask_q[k-1][k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= '0;
    end else begin
      if (en_st[0]) begin
        st_v_q[0] <= s1_leave && s1_ctl_q.res;
      end
      for (int k = 1; k < NST; k++) begin
        if (en_st[k]) begin
          st_v_q[k] <= st_v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (en_st[k]) begin
        st_tap_q[k]  <= st_tap_d[k];
        st_mask_q[k] <= st_mask_d[k];
        st_eof_q[k]  <= st_eof_d[k];
        for (int ch = 0; ch < 3; ch++) begin
          st_acc_q[k][ch]  <= st_acc_d[k][ch];
          st_prod_q[k][ch] <= st_prod_d[k][ch];
        end
      end
    end
  end

  // Output register
  logic [PIX_W-1:0] out_data_q, out_data_d;
  logic             out_last_q;
  logic signed [CH_W:0] fin_acc [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      fin_acc[ch] = acc_step(st_acc_q[NST-1][ch], st_prod_q[NST-1][ch]);
      out_data_d[CH_W*ch +: CH_W] = fin_acc[ch][CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= st_v_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_data_q <= out_data_d;
      out_last_q <= st_eof_q[NST-1];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/rgbconv_chk.sv
// Port-level checker for the convolution core, bound to the top level.
`default_nettype none

module rgbconv_chk
  import rgbconv_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [PIX_W-1:0]  s_axis_tdata,   // pix_red, pix_green, pix_blue
  input logic              s_axis_tuser,   // req_type
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [PIX_W-1:0]  m_axis_tdata,   // out_red, out_green, out_blue
  input logic              m_axis_tlast,   // end_of_frame
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [APB_AW-1:0] paddr,
  input logic [APB_DW-1:0] pwdata,
  input logic [APB_DW-1:0] prdata,
  input logic              pready
);

  logic wr_req;
  logic rd_req;

  assign wr_req = psel && penable && pwrite && pready;
  assign rd_req = psel && !pwrite;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output request changed while stalled");

  a_width_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_req && paddr[APB_AW-1:3] == REG_WIDTH) ##1 (rd_req && paddr == $past(paddr))
    |-> prdata == APB_DW'($past(pwdata[FW_W-1:0])))
    else $error("frame width readback mismatch");

  a_coef_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_req && paddr[APB_AW-1:3] == REG_COEF_NEXT) ##1 (rd_req && paddr == $past(paddr))
    |-> prdata == APB_DW'($past(pwdata[COEFS_W-1:0])))
    else $error("coefficient readback mismatch");

endmodule

bind rgb_3x3_convolution_wrap_core rgbconv_chk u_rgbconv_chk (.*);

`default_nettype wire

// File: verif/tb_rgb_3x3_convolution_wrap_core.sv
// Self-checking testbench for the RGB 3x3 convolution core: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module tb_rgb_3x3_convolution_wrap_core;
  import rgbconv_pkg::*;

  localparam int DRAIN_GAP      = 20;    // block latency plus margin
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_AT        = 1000;  // result count that starts the long receiver hold-off
  localparam int HOLD_CYCLES    = 600;
  localparam int RANDOM_ITEMS   = 650;
  localparam logic [APB_AW-1:0] UNMAPPED_ADDR = APB_AW'(8 * (int'(REG_COEF_NEXT) + 1));

  typedef struct {
    req_type_e        kind;
    logic [PIX_W-1:0] rgb;
  } pixel_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] rgb;  // red in the low byte
    logic             eof;
  } filtered_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [PIX_W-1:0]  s_axis_tdata = '0;    // pix_red, pix_green, pix_blue
  logic              s_axis_tuser = 1'b0;  // req_type
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [PIX_W-1:0]  m_axis_tdata;         // out_red, out_green, out_blue
  logic              m_axis_tlast;         // end_of_frame
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  rgb_3x3_convolution_wrap_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  pixel_req_t pixel_req_q[$];
  filtered_t  filtered_q[$];
  int         send_idle_pct = 25;
  int         recv_idle_pct = 60;
  int         mismatches = 0;
  int         results_seen = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;

  // Predictor state
  logic [FW_W-1:0]    frame_w = FRAME_WIDTH_RST;
  logic [FH_W-1:0]    frame_h = FRAME_HEIGHT_RST;
  logic [COEFS_W-1:0] coef_rows[3] = '{COEF_PREV_RST, COEF_CUR_RST, COEF_NEXT_RST};
  logic [PIX_W-1:0]   older_line[MAX_WIDTH_DEF];
  logic [PIX_W-1:0]   newer_line[MAX_WIDTH_DEF];
  logic [PIX_W-1:0]   win[NTAP];
  int                 col_pos;
  int                 row_pos;

  function automatic int line_width();
    if (frame_w == 0) return 1;
    if (frame_w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(frame_w);
  endfunction

  function automatic int frame_rows();
    return (frame_h == 0) ? 1 : int'(frame_h);
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    for (int k = 0; k < NTAP; k++) win[k] = '0;
  endfunction

  function automatic void apply_reg(input reg_idx_e idx, input logic [APB_DW-1:0] val);
    case (idx)
      REG_WIDTH: begin
        frame_w = val[FW_W-1:0];
        restart_frame();
      end
      REG_HEIGHT: begin
        frame_h = val[FH_W-1:0];
        restart_frame();
      end
      REG_COEF_PREV: coef_rows[0] = val[COEFS_W-1:0];
      REG_COEF_CUR:  coef_rows[1] = val[COEFS_W-1:0];
      REG_COEF_NEXT: coef_rows[2] = val[COEFS_W-1:0];
      default: ;
    endcase
  endfunction

  // Output (ro, co); window column slot cs holds column co.
  function automatic logic [PIX_W-1:0] filter_pixel(input int ro, input int co, input int cs);
    longint acc[3];
    longint scale, cf, p, t;
    int w, h, rr, cc, slot;
    logic [PIX_W-1:0] px;
    w = line_width();
    h = frame_rows();
    scale = longint'(1) << COEF_FRAC_DEF;
    acc = '{0, 0, 0};
    for (int kr = 0; kr < 3; kr++) begin
      rr = ro + kr - 1;
      for (int kc = 0; kc < 3; kc++) begin
        cc = co + kc - 1;
        slot = cs + kc - 1;
        // skip taps outside the image
        if (rr >= 0 && rr < h && cc >= 0 && cc < w && slot >= 0 && slot <= 2) begin
          cf = $signed(coef_rows[kr][COEF_W*kc +: COEF_W]);
          px = win[kr*3 + slot];
          for (int ch = 0; ch < 3; ch++) begin
            p = longint'(px[CH_W*ch +: CH_W]);
            t = acc[ch] * scale + cf * p;
            acc[ch] = (t / scale) % 256;
          end
        end
      end
    end
    return {acc[2][7:0], acc[1][7:0], acc[0][7:0]};
  endfunction

  function automatic void advance_filter(input req_type_e kind, input logic [PIX_W-1:0] rgb);
    int w, h, r, c;
    bit drain;
    logic [PIX_W-1:0] px, older, newer;
    w = line_width();
    h = frame_rows();
    r = row_pos;
    c = col_pos;
    drain = (kind == REQ_DRAIN);
    // drop early drains and pixels arriving while the frame drains
    if (drain ? (r < h) : (r >= h)) return;
    if (c >= w) c = 0;
    if (c == 0 && r >= 2) begin
      if (r - 2 == h - 1) begin
        filtered_q.push_back('{rgb: filter_pixel(r - 2, w - 1, 2), eof: 1'b1});
        restart_frame();
        return;
      end
      filtered_q.push_back('{rgb: filter_pixel(r - 2, w - 1, 2), eof: 1'b0});
    end
    px = drain ? '0 : rgb;
    older = older_line[c];
    newer = newer_line[c];
    older_line[c] = newer;
    newer_line[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k*3]     = win[k*3 + 1];
      win[k*3 + 1] = win[k*3 + 2];
    end
    win[2] = older;
    win[5] = newer;
    win[8] = px;
    if (c >= 1 && r >= 1)
      filtered_q.push_back('{rgb: filter_pixel(r - 1, c - 1, 1), eof: 1'b0});
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h (result %0d)", field, got, want, results_seen);
    mismatches++;
  endtask

  // Driver: offer the oldest pending request, predict on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        advance_filter(pixel_req_q[0].kind, pixel_req_q[0].rgb);
        void'(pixel_req_q.pop_front());
      end
      if (pixel_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pixel_req_q[0].rgb;
        s_axis_tuser  <= pixel_req_q[0].kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check results, stall the output
  always @(posedge clk_i) begin
    filtered_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          report_mismatch("result with nothing pending", {m_axis_tlast, m_axis_tdata}, '0);
        end else begin
          want = filtered_q.pop_front();
          for (int ch = 0; ch < 3; ch++)
            if (m_axis_tdata[CH_W*ch +: CH_W] !== want.rgb[CH_W*ch +: CH_W])
              report_mismatch((ch == 0) ? "red" : (ch == 1) ? "green" : "blue",
                              m_axis_tdata[CH_W*ch +: CH_W], want.rgb[CH_W*ch +: CH_W]);
          if (m_axis_tlast !== want.eof)
            report_mismatch("end_of_frame", m_axis_tlast, want.eof);
        end
        results_seen++;
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      // hold off long enough for the core to fill and stall its input
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("rgb_3x3_convolution_wrap_core regression: fail");
      $finish;
    end
  end

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [APB_DW-1:0] val);
    apb_write({idx, 3'b000}, val);
    apply_reg(idx, val);
  endtask

  // Wait until every request is taken and every result is back, then let the pipe empty.
  task automatic wait_idle();
    while (pixel_req_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  function automatic void push_pixel(input logic [PIX_W-1:0] rgb);
    pixel_req_q.push_back('{kind: REQ_PIXEL, rgb: rgb});
  endfunction

  function automatic void push_drain();
    pixel_req_q.push_back('{kind: REQ_DRAIN, rgb: PIX_W'($urandom)});
  endfunction

  function automatic logic [COEFS_W-1:0] pick_coefs();
    logic [COEFS_W-1:0] v;
    for (int k = 0; k < 3; k++)
      case ($urandom_range(5))
        0: v[COEF_W*k +: COEF_W] = 16'h0000;
        1: v[COEF_W*k +: COEF_W] = 16'h7FFF;
        2: v[COEF_W*k +: COEF_W] = 16'h8000;
        3: v[COEF_W*k +: COEF_W] = 16'hFFFF;
        4: v[COEF_W*k +: COEF_W] = 16'($urandom_range(0, 16'h2000)) - 16'h1000;
        default: v[COEF_W*k +: COEF_W] = 16'($urandom);
      endcase
    return v;
  endfunction

  // Queue one frame: w*h pixels then w+1 drains. Noise adds requests the core must drop;
  // a broken frame stops early. Returns the count of requests that take effect.
  function automatic int queue_frame(input int w, input int h, input bit noisy, input bit broken);
    int n_pix, cut, counted;
    n_pix = w * h;
    cut = broken ? $urandom_range(0, n_pix + w) : -1;
    counted = 0;
    for (int i = 0; i < n_pix + w + 1; i++) begin
      if (i == cut) return counted;
      if (i < n_pix) push_pixel(PIX_W'($urandom));
      else push_drain();
      counted++;
      if (noisy && $urandom_range(5) == 0) begin
        if (i < n_pix - 1) push_drain();
        else if (i >= n_pix && i < n_pix + w) push_pixel(PIX_W'($urandom));
      end
    end
    return counted;
  endfunction

  initial begin
    int w, h, random_count, seg;
    bit frame_open;
    restart_frame();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: early drain, then row 0 and a few pixels of row 1
    push_drain();
    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);
    push_pixel(24'hA5A5A5);
    push_pixel(24'h5A5A5A);
    for (int i = 0; i < 641; i++) push_pixel(PIX_W'($urandom));
    wait_idle();

    // height-one frame with extreme coefficients, early drain and pixel during drain
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 1);
    write_reg(REG_COEF_PREV, 48'h7FFF_7FFF_7FFF);
    write_reg(REG_COEF_CUR, 48'h8000_8000_8000);
    write_reg(REG_COEF_NEXT, 48'hFFFF_FFFF_FFFF);
    push_pixel(24'hFFFFFF);
    push_drain();
    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);
    push_drain();
    push_pixel(24'h123456);
    repeat (3) push_drain();
    wait_idle();

    // zero size registers clamp to one; upper write bits masked
    write_reg(REG_WIDTH, '0);
    write_reg(REG_HEIGHT, '0);
    write_reg(REG_COEF_PREV, '1);
    write_reg(REG_COEF_CUR, '1);
    write_reg(REG_COEF_NEXT, '1);
    push_pixel(24'h80FF01);
    repeat (2) push_drain();
    wait_idle();

    // tallest frame, abandoned part way
    write_reg(REG_WIDTH, 5);
    write_reg(REG_HEIGHT, 16'hFFFF);
    write_reg(REG_COEF_CUR, pick_coefs());
    for (int i = 0; i < 17; i++) push_pixel(PIX_W'($urandom));
    wait_idle();

    // coefficient change mid frame; unmapped write must be ignored
    write_reg(REG_WIDTH, 4);
    write_reg(REG_HEIGHT, 4);
    write_reg(REG_COEF_PREV, '0);
    write_reg(REG_COEF_NEXT, pick_coefs());
    for (int i = 0; i < 9; i++) push_pixel(PIX_W'($urandom));
    wait_idle();
    write_reg(REG_COEF_CUR, pick_coefs());
    apb_write(UNMAPPED_ADDR, '1);
    for (int i = 0; i < 7; i++) push_pixel(PIX_W'($urandom));
    repeat (5) push_drain();
    wait_idle();

    // widest line, full frame
    write_reg(REG_WIDTH, MAX_WIDTH_DEF);
    write_reg(REG_HEIGHT, 2);
    write_reg(REG_COEF_PREV, pick_coefs());
    write_reg(REG_COEF_CUR, pick_coefs());
    write_reg(REG_COEF_NEXT, pick_coefs());
    void'(queue_frame(MAX_WIDTH_DEF, 2, 1'b0, 1'b0));
    wait_idle();

    // oversize width clamps to the line store depth
    write_reg(REG_WIDTH, 12'hFFF);
    write_reg(REG_HEIGHT, 3);
    for (int i = 0; i < MAX_WIDTH_DEF + 3; i++) push_pixel(PIX_W'($urandom));
    wait_idle();

    random_count = 0;
    frame_open = 1'b1;
    while (random_count < RANDOM_ITEMS) begin
      seg = random_count * 3 / RANDOM_ITEMS;
      send_idle_pct = (seg == 0) ? 25 : (seg == 1) ? 60 : 0;
      recv_idle_pct = (seg == 0) ? 60 : (seg == 1) ? 25 : 0;
      w = ($urandom_range(9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      h = $urandom_range(1, 5);
      // keep the current size now and then so frames run back to back
      if (frame_open || $urandom_range(3) != 0) begin
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
      end else begin
        w = line_width();
        h = frame_rows();
      end
      for (int k = 0; k < 3; k++)
        if ($urandom_range(2) == 0) write_reg(reg_idx_e'(int'(REG_COEF_PREV) + k), pick_coefs());
      frame_open = ($urandom_range(7) == 0);
      random_count += queue_frame(w, h, $urandom_range(3) == 0, frame_open);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("rgb_3x3_convolution_wrap_core regression: pass");
    end else begin
      $display("rgb_3x3_convolution_wrap_core regression: fail");
    end
    $finish;
  end

endmodule
